@@ src/text_console_cursor_engine_assert.svh @@
// Assertion macros for the text console cursor engine checkers.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// same-cycle implication
`define TCCE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcce assertion failed");

// next-cycle implication
`define TCCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcce assertion failed");

`endif

@@ src/tcce_pkg.sv @@
// Shared types, constants and codes for the text console cursor engine.
// No dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);

    // field widths of the item and result
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [7:0] ATTR_RESET = 8'h0F;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LAST    = 8'h7F;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } req_code_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic put;
        logic home;
        logic cnt_clr;
        logic cnt_inc;
        logic rd_scroll;
        logic wr_scroll;
        logic wr_fill;
        logic fill_reset;
        logic rd_cell;
        logic load_result;
    } tcce_cmd_t;

    typedef struct packed {
        logic scroll_req;
        logic copy_last;
        logic fill_last;
        logic out_free;
    } tcce_stat_t;

endpackage

@@ src/tcce_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on tcce_pkg for field widths.
`timescale 1ns / 1ps

interface tcce_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [7:0]                  char_code;
    logic [tcce_pkg::POS_W-1:0]  cell_index;

    modport source (output valid, req_type, char_code, cell_index, input ready);
    modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcce_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tcce_pkg::COL_W-1:0]  cursor_col;
    logic [tcce_pkg::ROW_W-1:0]  cursor_row;
    logic [tcce_pkg::POS_W-1:0]  cursor_pos;
    logic [tcce_pkg::CELL_W-1:0] cell_value;

    modport source (output valid, cursor_col, cursor_row, cursor_pos, cell_value,
                    input ready);
    modport sink   (input valid, cursor_col, cursor_row, cursor_pos, cell_value,
                    output ready);
endinterface

@@ src/tcce_ctrl.sv @@
// Sequencer for the text console: decodes items and walks fill/scroll passes.
// Depends on tcce_pkg; drives tcce_dpath through the command struct.
`timescale 1ns / 1ps

module tcce_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic [1:0]             req_type,
    output logic                   req_ready,
    output tcce_pkg::tcce_cmd_t    cmd,
    input  tcce_pkg::tcce_stat_t   stat
);

    tcce_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcce_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            tcce_pkg::ST_INIT:
            begin
                // power-up clearing pass with the reset attribute
                cmd.wr_fill    = 1'b1;
                cmd.fill_reset = 1'b1;
                cmd.cnt_inc    = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.cnt_inc = 1'b0;
                    cmd.cnt_clr = 1'b1;
                    state_next  = tcce_pkg::ST_IDLE;
                end
            end
            tcce_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch = 1'b1;
                    case (req_type)
                        tcce_pkg::REQ_PUT:
                        begin
                            state_next = tcce_pkg::ST_PUT;
                        end
                        tcce_pkg::REQ_CLEAR:
                        begin
                            cmd.home    = 1'b1;
                            cmd.cnt_clr = 1'b1;
                            state_next  = tcce_pkg::ST_FILL;
                        end
                        tcce_pkg::REQ_READ:
                        begin
                            state_next = tcce_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = tcce_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            tcce_pkg::ST_PUT:
            begin
                cmd.put     = 1'b1;
                cmd.cnt_clr = 1'b1;
                state_next  = stat.scroll_req ? tcce_pkg::ST_SCROLL_RD : tcce_pkg::ST_DONE;
            end
            tcce_pkg::ST_SCROLL_RD:
            begin
                cmd.rd_scroll = 1'b1;
                state_next    = tcce_pkg::ST_SCROLL_WR;
            end
            tcce_pkg::ST_SCROLL_WR:
            begin
                cmd.wr_scroll = 1'b1;
                cmd.cnt_inc   = 1'b1;
                // counter lands on the bottom line after the last copy
                state_next    = stat.copy_last ? tcce_pkg::ST_FILL : tcce_pkg::ST_SCROLL_RD;
            end
            tcce_pkg::ST_FILL:
            begin
                cmd.wr_fill = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.cnt_inc = 1'b0;
                    cmd.cnt_clr = 1'b1;
                    state_next  = tcce_pkg::ST_DONE;
                end
            end
            tcce_pkg::ST_READ:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = tcce_pkg::ST_DONE;
            end
            tcce_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = tcce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcce_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/tcce_dpath.sv @@
// Datapath: screen store, cursor, attribute, pass counter and result register.
// Depends on tcce_pkg and tcce_rsp_if; controlled by tcce_ctrl.
`timescale 1ns / 1ps

module tcce_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [7:0]                          cfg_wr_data,
    input  logic [1:0]                          req_type,
    input  logic [7:0]                          char_code,
    input  logic [tcce_pkg::POS_W-1:0]          cell_index,
    input  tcce_pkg::tcce_cmd_t                 cmd,
    output tcce_pkg::tcce_stat_t                stat,
    tcce_rsp_if.source                          rsp
);

    localparam int COLX_W = tcce_pkg::COL_W + 1;
    localparam int ROWX_W = tcce_pkg::ROW_W + 1;

    logic [tcce_pkg::CELL_W-1:0] mem [tcce_pkg::CELLS];

    logic [7:0]                    attr_reg;
    logic [tcce_pkg::COL_W-1:0]    col_reg;
    logic [tcce_pkg::ROW_W-1:0]    row_reg;
    logic [tcce_pkg::ADDR_W-1:0]   cnt_reg;
    logic [1:0]                    type_reg;
    logic [7:0]                    char_reg;
    logic [tcce_pkg::POS_W-1:0]    cell_reg;
    logic [tcce_pkg::CELL_W-1:0]   rdata_reg;

    logic                          out_valid_reg;
    logic [tcce_pkg::COL_W-1:0]    out_col_reg;
    logic [tcce_pkg::ROW_W-1:0]    out_row_reg;
    logic [tcce_pkg::POS_W-1:0]    out_pos_reg;
    logic [tcce_pkg::CELL_W-1:0]   out_cell_reg;

    // put-character cursor step
    logic                          printable;
    logic [COLX_W-1:0]             col_ext;
    logic [COLX_W-1:0]             col_step;
    logic [ROWX_W-1:0]             row_step;
    logic [COLX_W-1:0]             col_wrap;
    logic [ROWX_W-1:0]             row_wrap;
    logic [tcce_pkg::COL_W-1:0]    col_put;
    logic [tcce_pkg::ROW_W-1:0]    row_put;
    logic [tcce_pkg::ADDR_W-1:0]   cur_addr;
    logic                          scroll_req;

    logic [tcce_pkg::CELL_W-1:0]   blank;
    logic                          wr_en;
    logic [tcce_pkg::ADDR_W-1:0]   wr_addr;
    logic [tcce_pkg::CELL_W-1:0]   wr_data;
    logic                          rd_en;
    logic [tcce_pkg::ADDR_W-1:0]   rd_addr;
    logic                          cell_in_range;

    assign printable = (char_reg >= tcce_pkg::CH_SPACE) && (char_reg <= tcce_pkg::CH_LAST);
    assign col_ext   = {1'b0, col_reg};
    assign cur_addr  = tcce_pkg::ADDR_W'(row_reg * tcce_pkg::COLUMNS + col_reg);

    always_comb
    begin
        col_step = col_ext;
        row_step = {1'b0, row_reg};
        if (char_reg == tcce_pkg::CH_BS)
        begin
            if (col_reg != '0)
            begin
                col_step = col_ext - COLX_W'(1);
            end
        end
        else if (char_reg == tcce_pkg::CH_TAB)
        begin
            col_step = COLX_W'((col_ext / tcce_pkg::TAB_STOP + 1) * tcce_pkg::TAB_STOP);
        end
        else if (char_reg == tcce_pkg::CH_CR)
        begin
            col_step = '0;
        end
        else if (char_reg == tcce_pkg::CH_LF)
        begin
            col_step = '0;
            row_step = row_step + ROWX_W'(1);
        end
        else if (printable)
        begin
            col_step = col_ext + COLX_W'(1);
        end

        col_wrap = col_step;
        row_wrap = row_step;
        if (col_step >= COLX_W'(tcce_pkg::COLUMNS))
        begin
            col_wrap = '0;
            row_wrap = row_step + ROWX_W'(1);
        end

        scroll_req = (row_wrap >= ROWX_W'(tcce_pkg::ROWS));
        col_put = col_wrap[tcce_pkg::COL_W-1:0];
        row_put = scroll_req ? tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)
                             : row_wrap[tcce_pkg::ROW_W-1:0];
    end

    assign stat.scroll_req = scroll_req;
    assign stat.copy_last = (cnt_reg == tcce_pkg::ADDR_W'(tcce_pkg::COPY_CELLS - 1));
    assign stat.fill_last = (cnt_reg == tcce_pkg::ADDR_W'(tcce_pkg::CELLS - 1));
    assign stat.out_free  = !out_valid_reg || rsp.ready;

    // memory port steering
    assign blank = {(cmd.fill_reset ? tcce_pkg::ATTR_RESET : attr_reg), tcce_pkg::CH_SPACE};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = blank;
        if (cmd.put && printable)
        begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = {attr_reg, char_reg};
        end
        else if (cmd.wr_scroll)
        begin
            wr_en   = 1'b1;
            wr_data = rdata_reg;
        end
        else if (cmd.wr_fill)
        begin
            wr_en = 1'b1;
        end
    end

    assign cell_in_range = (cell_reg < tcce_pkg::POS_W'(tcce_pkg::CELLS));
    assign rd_en   = cmd.rd_scroll || (cmd.rd_cell && cell_in_range);
    assign rd_addr = cmd.rd_scroll ? tcce_pkg::ADDR_W'(cnt_reg + tcce_pkg::COLUMNS)
                                   : cell_reg[tcce_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= tcce_pkg::ATTR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
            if (cmd.home)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.put)
            begin
                col_reg <= col_put;
                row_reg <= row_put;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + tcce_pkg::ADDR_W'(1);
            end
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            type_reg <= req_type;
            char_reg <= char_code;
            cell_reg <= cell_index;
        end
        if (cmd.load_result)
        begin
            out_col_reg  <= col_reg;
            out_row_reg  <= row_reg;
            out_pos_reg  <= tcce_pkg::POS_W'(row_reg * tcce_pkg::COLUMNS + col_reg);
            out_cell_reg <= (type_reg == tcce_pkg::REQ_READ && cell_in_range) ? rdata_reg
                                                                              : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.cursor_col = out_col_reg;
    assign rsp.cursor_row = out_row_reg;
    assign rsp.cursor_pos = out_pos_reg;
    assign rsp.cell_value = out_cell_reg;

endmodule

@@ src/text_console_cursor_engine.sv @@
// Text console cursor engine, 80x25 cells; top level of tcce_ctrl and tcce_dpath.
// Put/read: PUT or READ, then DONE loads the result; nop: DONE. Next item in IDLE.
// Scroll: a read and a write state per copied cell (1920), then fills 80 cells.
// Clear walks all 2000 cells, one per cycle, before its result.
// Reset: clearing pass over all 2000 cells with ready low; cfg writes still taken.
`timescale 1ns / 1ps

module text_console_cursor_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    tcce_req_if.sink    req,
    tcce_rsp_if.source  rsp
);

    tcce_pkg::tcce_cmd_t  cmd;
    tcce_pkg::tcce_stat_t stat;

    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    tcce_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_type    (req.req_type),
        .char_code   (req.char_code),
        .cell_index  (req.cell_index),
        .cmd         (cmd),
        .stat        (stat),
        .rsp         (rsp)
    );

endmodule

@@ src/tcce_checker.sv @@
// Port-level checks on the text console cursor engine, bound to the top level.
// Depends on tcce_pkg and text_console_cursor_engine_assert.svh.
`timescale 1ns / 1ps
`include "text_console_cursor_engine_assert.svh"

module tcce_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [tcce_pkg::COL_W-1:0]  cursor_col,
    input  logic [tcce_pkg::ROW_W-1:0]  cursor_row,
    input  logic [tcce_pkg::POS_W-1:0]  cursor_pos,
    input  logic [tcce_pkg::CELL_W-1:0] cell_value
);

    `TCCE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(cursor_pos) && $stable(cell_value))
    `TCCE_ASSERT_NOW(a_col_range, rsp_valid, cursor_col < tcce_pkg::COL_W'(tcce_pkg::COLUMNS))
    `TCCE_ASSERT_NOW(a_row_range, rsp_valid, cursor_row < tcce_pkg::ROW_W'(tcce_pkg::ROWS))
    `TCCE_ASSERT_NOW(a_pos_match, rsp_valid, cursor_pos == tcce_pkg::POS_W'(cursor_row * tcce_pkg::COLUMNS + cursor_col))

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cursor_col (rsp.cursor_col),
    .cursor_row (rsp.cursor_row),
    .cursor_pos (rsp.cursor_pos),
    .cell_value (rsp.cell_value)
);
